### sv/fac_pkg.sv
// ----------------------------------------------------------------------------
// fac_pkg: shared types and constants for the frustum AABB cull core
// Function codes, iterative unit request, saturation and magnitude helpers.
// ----------------------------------------------------------------------------
package fac_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int PLANE_WORDS = PLANE_COUNT * 4;
  localparam int PLANE_AW    = $clog2(PLANE_WORDS);

  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_EXTRACT = 2'd1;
  localparam logic [1:0] FUNC_TEST    = 2'd2;

  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } fac_op_t;

  typedef struct packed {
    logic    start;
    fac_op_t op;
  } fac_iter_req_t;

  // clamp a 33-bit signed sum to 32 bits
  function automatic logic [31:0] sat33(input logic signed [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? 32'(-v) : v;
    return r;
  endfunction

endpackage

### sv/fac_if.sv
// ----------------------------------------------------------------------------
// fac channel interfaces
// Item, result and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fac_item_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  func;
  logic        [1:0]  row_index;
  logic signed [31:0] row_elem_0;
  logic signed [31:0] row_elem_1;
  logic signed [31:0] row_elem_2;
  logic signed [31:0] row_elem_3;
  logic signed [31:0] box_min_x;
  logic signed [31:0] box_min_y;
  logic signed [31:0] box_min_z;
  logic signed [31:0] box_max_x;
  logic signed [31:0] box_max_y;
  logic signed [31:0] box_max_z;
  modport source (output valid, func, row_index, row_elem_0, row_elem_1, row_elem_2,
                  row_elem_3, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                  box_max_z, input ready);
  modport sink (input valid, func, row_index, row_elem_0, row_elem_1, row_elem_2,
                row_elem_3, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                box_max_z, output ready);
endinterface

interface fac_result_if;
  logic valid;
  logic ready;
  logic in_view;
  logic box_invalid;
  modport source (output valid, in_view, box_invalid, input ready);
  modport sink (input valid, in_view, box_invalid, output ready);
endinterface

interface fac_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] margin;
  modport source (output valid, margin, input ready);
  modport sink (input valid, margin, output ready);
endinterface

### sv/frustum_aabb_cull_core.sv
// ----------------------------------------------------------------------------
// frustum_aabb_cull_core: Q16.16 view-frustum culling of axis-aligned boxes
//
// Channels: item (sink) carries one word per command: func 0 loads matrix
// row row_index, func 1 extracts six normalized planes from the matrix,
// func 2 tests a box. result (source) returns exactly one word per item:
// in_view / box_invalid (both 0 for load, extract and unused func 3).
// cfg (sink, always ready) writes the margin register; write only when idle.
// One item at a time; item.ready is high only while the sequencer is idle.
// Per command:
//   load     one matrix word written per cycle
//   test     24 plane words streamed through one 32x32 multiplier
//   invalid  corner compare at accept, planes skipped
//   extract  paced by the shared bit-serial sqrt/divide unit
//            (32 sqrt steps, 48 divide steps per coeff).
// A finished result sits in the output register; a new item is taken while
// it waits, and the next result is held back until the receiver takes it.
// Reset: planes read as zero until the first extract, margin is zero; the
// matrix holds nothing defined until loaded. No clearing pass.
// ----------------------------------------------------------------------------
module frustum_aabb_cull_core (
  input logic          clk,
  input logic          rst,
  fac_item_if.sink     item,
  fac_result_if.source result,
  fac_cfg_if.sink      cfg
);
  import fac_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOAD  = 9'b000000010,
    S_EXRD  = 9'b000000100,
    S_EXSQ  = 9'b000001000,
    S_SQRT  = 9'b000010000,
    S_DIVGO = 9'b000100000,
    S_DIVW  = 9'b001000000,
    S_TEST  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;
  logic [4:0]  cnt;
  logic [2:0]  pidx;
  logic [1:0]  kidx;
  logic        built;
  logic        ovalid;
  logic [30:0] margin;
  logic        hit;

  // captured item
  logic [1:0]         func_r;
  logic [1:0]         row_r;
  logic signed [31:0] elem [4];
  logic signed [31:0] lo [3];
  logic signed [31:0] hi [3];
  logic               bad;
  logic               res_view;
  logic               res_inv;

  // matrix store, 16 words, two registered read ports
  logic [31:0] mat [16];
  logic        mat_we;
  logic [3:0]  mat_wa;
  logic [3:0]  ma_addr;
  logic [3:0]  mb_addr;
  logic signed [31:0] ma_q;
  logic signed [31:0] mb_q;

  // plane store, reads as zero before the first extract
  logic [31:0] pm [PLANE_WORDS];
  logic        pm_we;
  logic [31:0] pm_wd;
  logic signed [31:0] pm_q;

  // extract datapath
  logic signed [31:0] pl [4];
  logic [1:0]         kd;
  logic [1:0]         pl_sel;
  logic [31:0]        pl_mag;
  logic [63:0]        sqprod;
  logic [63:0]        sq;
  logic [31:0]        len;
  logic [31:0]        nv;
  logic               neg;

  // test datapath
  logic [1:0]         k2;
  logic signed [31:0] sel;
  logic signed [63:0] tprod;
  logic signed [32:0] dm;
  logic signed [67:0] term;
  logic signed [67:0] acc;
  logic signed [67:0] tsum;

  fac_iter_req_t req;
  logic          it_done;
  logic [47:0]   quo;
  logic [63:0]   it_num;

  assign item.ready    = (state == S_IDLE);
  assign cfg.ready     = 1'b1;
  assign result.valid  = ovalid;

  // ---- shared sqrt / divide unit -------------------------------------------
  assign pl_sel = (state == S_EXSQ) ? cnt[1:0] : kidx;
  assign pl_mag = mag32(pl[pl_sel]);
  assign it_num = (state == S_SQRT) ? sq : {16'h0000, pl_mag, 16'h0000};

  always_comb begin
    req.start = 1'b0;
    req.op    = OP_DIV;
    if (state == S_SQRT && cnt == 5'd0) begin
      req.start = 1'b1;
      req.op    = OP_SQRT;
    end else if (state == S_DIVGO && len != 32'd0) begin
      req.start = 1'b1;
    end
  end

  fac_iter u_iter (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .num  (it_num),
    .den  (len),
    .done (it_done),
    .quo  (quo)
  );

  // normalized coefficient: truncate toward zero, saturate
  always_comb begin
    neg = pl[kidx][31];
    if (|quo[47:31]) begin
      nv = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      nv = neg ? 32'(-quo[31:0]) : quo[31:0];
    end
  end

  // ---- memories ------------------------------------------------------------
  assign mat_we  = (state == S_LOAD) && (cnt < 5'd4);
  assign mat_wa  = {row_r, cnt[1:0]};
  assign ma_addr = {2'd3, cnt[1:0]};
  assign mb_addr = {pidx[2:1], cnt[1:0]};

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat[mat_wa] <= elem[cnt[1:0]];
    end
    ma_q <= mat[ma_addr];
    mb_q <= mat[mb_addr];
  end

  assign pm_we = ((state == S_DIVGO) && (len == 32'd0)) || ((state == S_DIVW) && it_done);
  assign pm_wd = (state == S_DIVGO) ? pl[kidx] : nv;

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pm[{pidx, kidx}] <= pm_wd;
    end
    pm_q <= built ? pm[cnt[PLANE_AW-1:0]] : '0;
  end

  // ---- box test terms ------------------------------------------------------
  // n*2c + |n|*2e collapses to n*2max for n >= 0 and n*2min for n < 0
  always_comb begin
    case (kd)
      2'd0:    sel = pm_q[31] ? lo[0] : hi[0];
      2'd1:    sel = pm_q[31] ? lo[1] : hi[1];
      default: sel = pm_q[31] ? lo[2] : hi[2];
    endcase
    tprod = pm_q * sel;
    dm    = {pm_q[31], pm_q} + $signed({2'b00, margin});
    tsum  = (k2 == 2'd0) ? term : (acc + term);
  end

  // ---- payload registers ---------------------------------------------------
  always_ff @(posedge clk) begin
    kd <= cnt[1:0];
    k2 <= kd;
    if (kd == 2'd3) begin
      term <= {{18{dm[32]}}, dm, 17'h00000};
    end else begin
      term <= {{3{tprod[63]}}, tprod, 1'b0};
    end
    if (state == S_TEST && cnt >= 5'd2 && cnt <= 5'd25) begin
      acc <= tsum;
    end
    if (item.valid && item.ready) begin
      func_r  <= item.func;
      row_r   <= item.row_index;
      elem[0] <= item.row_elem_0;
      elem[1] <= item.row_elem_1;
      elem[2] <= item.row_elem_2;
      elem[3] <= item.row_elem_3;
      lo[0]   <= item.box_min_x;
      lo[1]   <= item.box_min_y;
      lo[2]   <= item.box_min_z;
      hi[0]   <= item.box_max_x;
      hi[1]   <= item.box_max_y;
      hi[2]   <= item.box_max_z;
      bad     <= (item.box_min_x > item.box_max_x) || (item.box_min_y > item.box_max_y) ||
                 (item.box_min_z > item.box_max_z);
    end
    // row3 +/- row(src), saturated
    if (state == S_EXRD && cnt != 5'd0) begin
      pl[kd] <= sat33(pidx[0] ? ({ma_q[31], ma_q} - {mb_q[31], mb_q})
                              : ({ma_q[31], ma_q} + {mb_q[31], mb_q}));
    end
    if (state == S_EXSQ) begin
      sqprod <= pl_mag * pl_mag;
      if (cnt == 5'd0) begin
        sq <= '0;
      end else begin
        sq <= sq + sqprod;
      end
    end
    if (state == S_SQRT && it_done) begin
      len <= quo[31:0];
    end
    if (state == S_DONE && (!ovalid || result.ready)) begin
      res_view <= (func_r == FUNC_TEST) && !bad && !hit;
      res_inv  <= (func_r == FUNC_TEST) && bad;
    end
  end

  assign result.in_view     = res_view;
  assign result.box_invalid = res_inv;

  // ---- sequencer -----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      pidx   <= '0;
      kidx   <= '0;
      built  <= 1'b0;
      ovalid <= 1'b0;
      margin <= '0;
      hit    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        margin <= cfg.margin;
      end
      if (state == S_DONE && (!ovalid || result.ready)) begin
        ovalid <= 1'b1;
      end else if (result.ready) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          cnt  <= '0;
          pidx <= '0;
          hit  <= 1'b0;
          if (item.valid) begin
            if (item.func == FUNC_LOAD) begin
              state <= S_LOAD;
            end else if (item.func == FUNC_EXTRACT) begin
              state <= S_EXRD;
            end else if (item.func == FUNC_TEST &&
                         !((item.box_min_x > item.box_max_x) ||
                           (item.box_min_y > item.box_max_y) ||
                           (item.box_min_z > item.box_max_z))) begin
              state <= S_TEST;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_LOAD: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd3) begin
            state <= S_DONE;
          end
        end
        S_EXRD: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd4) begin
            cnt   <= '0;
            state <= S_EXSQ;
          end
        end
        S_EXSQ: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd3) begin
            cnt   <= '0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          cnt <= 5'd1;
          if (it_done) begin
            kidx  <= '0;
            state <= S_DIVGO;
          end
        end
        S_DIVGO, S_DIVW: begin
          if ((state == S_DIVGO && len == 32'd0) || (state == S_DIVW && it_done)) begin
            kidx <= kidx + 2'd1;
            state <= S_DIVGO;
            if (kidx == 2'd3) begin
              cnt <= '0;
              if (pidx == 3'(PLANE_COUNT - 1)) begin
                built <= 1'b1;
                state <= S_DONE;
              end else begin
                pidx  <= pidx + 3'd1;
                state <= S_EXRD;
              end
            end
          end else if (state == S_DIVGO) begin
            state <= S_DIVW;
          end
        end
        S_TEST: begin
          cnt <= cnt + 5'd1;
          if (cnt >= 5'd2 && cnt <= 5'd25 && k2 == 2'd3 && tsum[67]) begin
            hit <= 1'b1;
          end
          if (cnt == 5'd26) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!ovalid || result.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---- assertions ----------------------------------------------------------
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> state != S_IDLE)
    else $error("item accepted but sequencer stayed idle");

  a_iter_done_expected: assert property (@(posedge clk) disable iff (rst)
    it_done |-> (state == S_SQRT || state == S_DIVW))
    else $error("sqrt/divide finished outside a waiting state");

  a_result_exclusive: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> !(result.in_view && result.box_invalid))
    else $error("box both in view and invalid");

  a_plane_range: assert property (@(posedge clk) disable iff (rst)
    pidx < 3'(PLANE_COUNT))
    else $error("plane index out of range");

endmodule

### sv/fac_iter.sv
// ----------------------------------------------------------------------------
// fac_iter: shared bit-serial square root / divide unit
// Sqrt: 64-bit radicand, two bits a cycle, 32-bit root. Divide: 48-bit
// dividend by 32-bit divisor, one bit a cycle, 48-bit quotient.
// ----------------------------------------------------------------------------
module fac_iter (
  input  logic                  clk,
  input  logic                  rst,
  input  fac_pkg::fac_iter_req_t req,
  input  logic [63:0]           num,
  input  logic [31:0]           den,
  output logic                  done,
  output logic [47:0]           quo
);
  import fac_pkg::*;

  logic        busy;
  fac_op_t     op;
  logic [5:0]  cnt;
  logic [35:0] rem;
  logic [63:0] work;
  logic [47:0] q;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        take;

  always_comb begin
    if (op == OP_SQRT) begin
      rem_sh = {rem[33:0], work[63:62]};
      trial  = {1'b0, q[32:0], 2'b01};
    end else begin
      rem_sh = {rem[34:0], work[47]};
      trial  = {4'b0000, den};
    end
    take = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      op   <= req.op;
      rem  <= '0;
      q    <= '0;
      work <= num;
      cnt  <= (req.op == OP_SQRT) ? 6'd31 : 6'd47;
    end else if (busy) begin
      rem  <= take ? (rem_sh - trial) : rem_sh;
      q    <= {q[46:0], take};
      work <= (op == OP_SQRT) ? {work[61:0], 2'b00} : {work[62:0], 1'b0};
      cnt  <= cnt - 6'd1;
    end
  end

  assign quo = q;

endmodule
